[hdl/kf9_pkg.sv]
// package with kasumi tables, subkey and round functions for the f9 mac
`timescale 1ns / 1ps
package kf9_pkg;

  typedef struct packed {
    logic        load_init;
    logic        load_pad;
    logic        load_extra;
    logic        load_final;
    logic        run;
    logic        chain_done;
    logic        clear;
  } ctrl_t;

  localparam logic [63:0] KeyMod = 64'hAAAAAAAAAAAAAAAA;

  typedef logic [15:0] word16_t;
  typedef word16_t [7:0] keyvec_t;

  function automatic logic [6:0] sbox7_f(input logic [6:0] x);
    logic [6:0] r;
    case (x)
      7'd0: r = 7'd54; 7'd1: r = 7'd50; 7'd2: r = 7'd62; 7'd3: r = 7'd56;
      7'd4: r = 7'd22; 7'd5: r = 7'd34; 7'd6: r = 7'd94; 7'd7: r = 7'd96;
      7'd8: r = 7'd38; 7'd9: r = 7'd6; 7'd10: r = 7'd63; 7'd11: r = 7'd93;
      7'd12: r = 7'd2; 7'd13: r = 7'd18; 7'd14: r = 7'd123; 7'd15: r = 7'd33;
      7'd16: r = 7'd55; 7'd17: r = 7'd113; 7'd18: r = 7'd39; 7'd19: r = 7'd114;
      7'd20: r = 7'd21; 7'd21: r = 7'd67; 7'd22: r = 7'd65; 7'd23: r = 7'd12;
      7'd24: r = 7'd47; 7'd25: r = 7'd73; 7'd26: r = 7'd46; 7'd27: r = 7'd27;
      7'd28: r = 7'd25; 7'd29: r = 7'd111; 7'd30: r = 7'd124; 7'd31: r = 7'd81;
      7'd32: r = 7'd53; 7'd33: r = 7'd9; 7'd34: r = 7'd121; 7'd35: r = 7'd79;
      7'd36: r = 7'd52; 7'd37: r = 7'd60; 7'd38: r = 7'd58; 7'd39: r = 7'd48;
      7'd40: r = 7'd101; 7'd41: r = 7'd127; 7'd42: r = 7'd40; 7'd43: r = 7'd120;
      7'd44: r = 7'd104; 7'd45: r = 7'd70; 7'd46: r = 7'd71; 7'd47: r = 7'd43;
      7'd48: r = 7'd20; 7'd49: r = 7'd122; 7'd50: r = 7'd72; 7'd51: r = 7'd61;
      7'd52: r = 7'd23; 7'd53: r = 7'd109; 7'd54: r = 7'd13; 7'd55: r = 7'd100;
      7'd56: r = 7'd77; 7'd57: r = 7'd1; 7'd58: r = 7'd16; 7'd59: r = 7'd7;
      7'd60: r = 7'd82; 7'd61: r = 7'd10; 7'd62: r = 7'd105; 7'd63: r = 7'd98;
      7'd64: r = 7'd117; 7'd65: r = 7'd116; 7'd66: r = 7'd76; 7'd67: r = 7'd11;
      7'd68: r = 7'd89; 7'd69: r = 7'd106; 7'd70: r = 7'd0; 7'd71: r = 7'd125;
      7'd72: r = 7'd118; 7'd73: r = 7'd99; 7'd74: r = 7'd86; 7'd75: r = 7'd69;
      7'd76: r = 7'd30; 7'd77: r = 7'd57; 7'd78: r = 7'd126; 7'd79: r = 7'd87;
      7'd80: r = 7'd112; 7'd81: r = 7'd51; 7'd82: r = 7'd17; 7'd83: r = 7'd5;
      7'd84: r = 7'd95; 7'd85: r = 7'd14; 7'd86: r = 7'd90; 7'd87: r = 7'd84;
      7'd88: r = 7'd91; 7'd89: r = 7'd8; 7'd90: r = 7'd35; 7'd91: r = 7'd103;
      7'd92: r = 7'd32; 7'd93: r = 7'd97; 7'd94: r = 7'd28; 7'd95: r = 7'd66;
      7'd96: r = 7'd102; 7'd97: r = 7'd31; 7'd98: r = 7'd26; 7'd99: r = 7'd45;
      7'd100: r = 7'd75; 7'd101: r = 7'd4; 7'd102: r = 7'd85; 7'd103: r = 7'd92;
      7'd104: r = 7'd37; 7'd105: r = 7'd74; 7'd106: r = 7'd80; 7'd107: r = 7'd49;
      7'd108: r = 7'd68; 7'd109: r = 7'd29; 7'd110: r = 7'd115; 7'd111: r = 7'd44;
      7'd112: r = 7'd64; 7'd113: r = 7'd107; 7'd114: r = 7'd108; 7'd115: r = 7'd24;
      7'd116: r = 7'd110; 7'd117: r = 7'd83; 7'd118: r = 7'd36; 7'd119: r = 7'd78;
      7'd120: r = 7'd42; 7'd121: r = 7'd19; 7'd122: r = 7'd15; 7'd123: r = 7'd41;
      7'd124: r = 7'd88; 7'd125: r = 7'd119; 7'd126: r = 7'd59; default: r = 7'd3;
    endcase
    return r;
  endfunction

  localparam logic [8:0] SBOX9 [512] = '{
    9'd167,9'd239,9'd161,9'd379,9'd391,9'd334,9'd9,9'd338,
    9'd38,9'd226,9'd48,9'd358,9'd452,9'd385,9'd90,9'd397,
    9'd183,9'd253,9'd147,9'd331,9'd415,9'd340,9'd51,9'd362,
    9'd306,9'd500,9'd262,9'd82,9'd216,9'd159,9'd356,9'd177,
    9'd175,9'd241,9'd489,9'd37,9'd206,9'd17,9'd0,9'd333,
    9'd44,9'd254,9'd378,9'd58,9'd143,9'd220,9'd81,9'd400,
    9'd95,9'd3,9'd315,9'd245,9'd54,9'd235,9'd218,9'd405,
    9'd472,9'd264,9'd172,9'd494,9'd371,9'd290,9'd399,9'd76,
    9'd165,9'd197,9'd395,9'd121,9'd257,9'd480,9'd423,9'd212,
    9'd240,9'd28,9'd462,9'd176,9'd406,9'd507,9'd288,9'd223,
    9'd501,9'd407,9'd249,9'd265,9'd89,9'd186,9'd221,9'd428,
    9'd164,9'd74,9'd440,9'd196,9'd458,9'd421,9'd350,9'd163,
    9'd232,9'd158,9'd134,9'd354,9'd13,9'd250,9'd491,9'd142,
    9'd191,9'd69,9'd193,9'd425,9'd152,9'd227,9'd366,9'd135,
    9'd344,9'd300,9'd276,9'd242,9'd437,9'd320,9'd113,9'd278,
    9'd11,9'd243,9'd87,9'd317,9'd36,9'd93,9'd496,9'd27,
    9'd487,9'd446,9'd482,9'd41,9'd68,9'd156,9'd457,9'd131,
    9'd326,9'd403,9'd339,9'd20,9'd39,9'd115,9'd442,9'd124,
    9'd475,9'd384,9'd508,9'd53,9'd112,9'd170,9'd479,9'd151,
    9'd126,9'd169,9'd73,9'd268,9'd279,9'd321,9'd168,9'd364,
    9'd363,9'd292,9'd46,9'd499,9'd393,9'd327,9'd324,9'd24,
    9'd456,9'd267,9'd157,9'd460,9'd488,9'd426,9'd309,9'd229,
    9'd439,9'd506,9'd208,9'd271,9'd349,9'd401,9'd434,9'd236,
    9'd16,9'd209,9'd359,9'd52,9'd56,9'd120,9'd199,9'd277,
    9'd465,9'd416,9'd252,9'd287,9'd246,9'd6,9'd83,9'd305,
    9'd420,9'd345,9'd153,9'd502,9'd65,9'd61,9'd244,9'd282,
    9'd173,9'd222,9'd418,9'd67,9'd386,9'd368,9'd261,9'd101,
    9'd476,9'd291,9'd195,9'd430,9'd49,9'd79,9'd166,9'd330,
    9'd280,9'd383,9'd373,9'd128,9'd382,9'd408,9'd155,9'd495,
    9'd367,9'd388,9'd274,9'd107,9'd459,9'd417,9'd62,9'd454,
    9'd132,9'd225,9'd203,9'd316,9'd234,9'd14,9'd301,9'd91,
    9'd503,9'd286,9'd424,9'd211,9'd347,9'd307,9'd140,9'd374,
    9'd35,9'd103,9'd125,9'd427,9'd19,9'd214,9'd453,9'd146,
    9'd498,9'd314,9'd444,9'd230,9'd256,9'd329,9'd198,9'd285,
    9'd50,9'd116,9'd78,9'd410,9'd10,9'd205,9'd510,9'd171,
    9'd231,9'd45,9'd139,9'd467,9'd29,9'd86,9'd505,9'd32,
    9'd72,9'd26,9'd342,9'd150,9'd313,9'd490,9'd431,9'd238,
    9'd411,9'd325,9'd149,9'd473,9'd40,9'd119,9'd174,9'd355,
    9'd185,9'd233,9'd389,9'd71,9'd448,9'd273,9'd372,9'd55,
    9'd110,9'd178,9'd322,9'd12,9'd469,9'd392,9'd369,9'd190,
    9'd1,9'd109,9'd375,9'd137,9'd181,9'd88,9'd75,9'd308,
    9'd260,9'd484,9'd98,9'd272,9'd370,9'd275,9'd412,9'd111,
    9'd336,9'd318,9'd4,9'd504,9'd492,9'd259,9'd304,9'd77,
    9'd337,9'd435,9'd21,9'd357,9'd303,9'd332,9'd483,9'd18,
    9'd47,9'd85,9'd25,9'd497,9'd474,9'd289,9'd100,9'd269,
    9'd296,9'd478,9'd270,9'd106,9'd31,9'd104,9'd433,9'd84,
    9'd414,9'd486,9'd394,9'd96,9'd99,9'd154,9'd511,9'd148,
    9'd413,9'd361,9'd409,9'd255,9'd162,9'd215,9'd302,9'd201,
    9'd266,9'd351,9'd343,9'd144,9'd441,9'd365,9'd108,9'd298,
    9'd251,9'd34,9'd182,9'd509,9'd138,9'd210,9'd335,9'd133,
    9'd311,9'd352,9'd328,9'd141,9'd396,9'd346,9'd123,9'd319,
    9'd450,9'd281,9'd429,9'd228,9'd443,9'd481,9'd92,9'd404,
    9'd485,9'd422,9'd248,9'd297,9'd23,9'd213,9'd130,9'd466,
    9'd22,9'd217,9'd283,9'd70,9'd294,9'd360,9'd419,9'd127,
    9'd312,9'd377,9'd7,9'd468,9'd194,9'd2,9'd117,9'd295,
    9'd463,9'd258,9'd224,9'd447,9'd247,9'd187,9'd80,9'd398,
    9'd284,9'd353,9'd105,9'd390,9'd299,9'd471,9'd470,9'd184,
    9'd57,9'd200,9'd348,9'd63,9'd204,9'd188,9'd33,9'd451,
    9'd97,9'd30,9'd310,9'd219,9'd94,9'd160,9'd129,9'd493,
    9'd64,9'd179,9'd263,9'd102,9'd189,9'd207,9'd114,9'd402,
    9'd438,9'd477,9'd387,9'd122,9'd192,9'd42,9'd381,9'd5,
    9'd145,9'd118,9'd180,9'd449,9'd293,9'd323,9'd136,9'd380,
    9'd43,9'd66,9'd60,9'd455,9'd341,9'd445,9'd202,9'd432,
    9'd8,9'd237,9'd15,9'd376,9'd436,9'd464,9'd59,9'd461};

  localparam logic [15:0] KCONST [8] = '{
    16'h0123, 16'h4567, 16'h89AB, 16'hCDEF, 16'hFEDC, 16'hBA98, 16'h7654, 16'h3210};

  function automatic logic [15:0] rot16(input logic [15:0] x, input int s);
    return (x << s) | (x >> (16 - s));
  endfunction

  function automatic logic [15:0] fi_f(input logic [15:0] x, input logic [15:0] key);
    logic [8:0] nine;
    logic [6:0] seven;
    nine  = x[15:7];
    seven = x[6:0];
    nine  = SBOX9[nine] ^ {2'b00, seven};
    seven = sbox7_f(seven) ^ nine[6:0];
    seven = seven ^ key[15:9];
    nine  = nine ^ key[8:0];
    nine  = SBOX9[nine] ^ {2'b00, seven};
    seven = sbox7_f(seven) ^ nine[6:0];
    return {seven, nine};
  endfunction

  // fo function: subkey index i from the key words k
  function automatic logic [31:0] fo_f(input logic [31:0] x, input keyvec_t k,
                                       input logic [2:0] i);
    logic [15:0] l;
    logic [15:0] r;
    logic [15:0] ko1, ko2, ko3, ki1, ki2, ki3;
    ko1 = rot16(k[i + 3'd1], 5);
    ko2 = rot16(k[i + 3'd5], 8);
    ko3 = rot16(k[i + 3'd6], 13);
    ki1 = k[i + 3'd4] ^ KCONST[i + 3'd4];
    ki2 = k[i + 3'd3] ^ KCONST[i + 3'd3];
    ki3 = k[i + 3'd7] ^ KCONST[i + 3'd7];
    l = x[31:16];
    r = x[15:0];
    l = fi_f(l ^ ko1, ki1) ^ r;
    r = fi_f(r ^ ko2, ki2) ^ l;
    l = fi_f(l ^ ko3, ki3) ^ r;
    return {r, l};
  endfunction

  function automatic logic [31:0] fl_f(input logic [31:0] x, input keyvec_t k,
                                       input logic [2:0] i);
    logic [15:0] l;
    logic [15:0] r;
    logic [15:0] kl1, kl2;
    kl1 = rot16(k[i], 1);
    kl2 = k[i + 3'd2] ^ KCONST[i + 3'd2];
    l = x[31:16];
    r = x[15:0];
    r = r ^ rot16(l & kl1, 1);
    l = l ^ rot16(r | kl2, 1);
    return {l, r};
  endfunction

endpackage

[hdl/kf9_ctrl.sv]
// controller state machine sequencing kasumi runs for the f9 mac
`timescale 1ns / 1ps
module kf9_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           last_i,
  input  logic [6:0]     valid_bits_i,
  input  logic           out_ready_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  output kf9_pkg::ctrl_t ctrl_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_BLK   = 3'd2;
  localparam logic [2:0] S_PAD   = 3'd3;
  localparam logic [2:0] S_EXTRA = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] rnd_q, rnd_d;
  logic       inmsg_q, inmsg_d;
  logic       last_q, last_d;
  logic [6:0] vb_q, vb_d;
  logic       acc;
  logic       rdone;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign acc         = in_valid_i && in_ready_o;
  assign rdone       = (rnd_q == 3'd7);

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    inmsg_d = inmsg_q;
    last_d  = last_q;
    vb_d    = vb_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          last_d = last_i;
          vb_d   = valid_bits_i;
          rnd_d  = 3'd0;
          if (!inmsg_q) begin
            ctrl_o.load_init = 1'b1;
            state_d = S_INIT;
          end else if (last_i && !valid_bits_i[6]) begin
            ctrl_o.load_pad = 1'b1;
            state_d = S_PAD;
          end else begin
            state_d = S_BLK;
          end
        end
      end
      S_INIT, S_BLK, S_PAD, S_EXTRA, S_FIN: begin
        ctrl_o.run = 1'b1;
        rnd_d = rnd_q + 3'd1;
        if (rdone) begin
          rnd_d = 3'd0;
          if (state_q != S_FIN) ctrl_o.chain_done = 1'b1;
          unique case (state_q)
            S_INIT: begin
              inmsg_d = 1'b1;
              if (last_q && !vb_q[6]) begin
                ctrl_o.load_pad = 1'b1;
                state_d = S_PAD;
              end else begin
                state_d = S_BLK;
              end
            end
            S_BLK: begin
              if (last_q) begin
                vb_d = 7'd0;
                ctrl_o.load_pad = 1'b1;
                state_d = S_PAD;
              end else begin
                state_d = S_IDLE;
              end
            end
            S_PAD: begin
              if (vb_q == 7'd63) begin
                ctrl_o.load_extra = 1'b1;
                state_d = S_EXTRA;
              end else begin
                ctrl_o.load_final = 1'b1;
                state_d = S_FIN;
              end
            end
            S_EXTRA: begin
              ctrl_o.load_final = 1'b1;
              state_d = S_FIN;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          ctrl_o.clear = 1'b1;
          inmsg_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rnd_q   <= '0;
      inmsg_q <= 1'b0;
      last_q  <= 1'b0;
      vb_q    <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      inmsg_q <= inmsg_d;
      last_q  <= last_d;
      vb_q    <= vb_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (rnd_q == 3'd0))
    else $error("round counter not parked");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_FIN)
    else $error("result without final cipher");
endmodule

[hdl/kf9_dpath.sv]
// datapath: kasumi round unit, chain and digest registers
`timescale 1ns / 1ps
module kf9_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  kf9_pkg::ctrl_t ctrl_i,
  input  logic [63:0]    ik_upper_i,
  input  logic [63:0]    ik_lower_i,
  input  logic [31:0]    count_value_i,
  input  logic [31:0]    fresh_value_i,
  input  logic           direction_i,
  input  logic           in_accept_i,
  input  logic [63:0]    data_block_i,
  input  logic [6:0]     valid_bits_i,
  output logic [31:0]    mac_value_o
);
  localparam logic [63:0] OneBitBlk = 64'h8000000000000000;

  logic [63:0] state_q, state_d;
  logic [63:0] chain_q, chain_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] blk_q, blk_d;
  logic [6:0]  vb_q, vb_d;
  logic        fin_q, fin_d;
  logic [2:0]  rnd_q, rnd_d;
  logic [63:0] khi, klo;
  kf9_pkg::keyvec_t kv;
  logic [31:0] l, r, t, nl, nr;
  logic [63:0] rnd_out;
  logic [63:0] pad_blk;
  logic [6:0]  pad_vb;
  logic [5:0]  v;
  logic [63:0] pad, mask, msg, cat;
  logic [63:0] pin;

  assign khi = fin_q ? (ik_upper_i ^ kf9_pkg::KeyMod) : ik_upper_i;
  assign klo = fin_q ? (ik_lower_i ^ kf9_pkg::KeyMod) : ik_lower_i;
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      kv[n]     = khi[63 - 16*n -: 16];
      kv[n + 4] = klo[63 - 16*n -: 16];
    end
  end

  // one round per cycle; odd rounds fl then fo
  always_comb begin
    l = state_q[63:32];
    r = state_q[31:0];
    if (!rnd_q[0]) begin
      t = kf9_pkg::fo_f(kf9_pkg::fl_f(l, kv, rnd_q), kv, rnd_q);
    end else begin
      t = kf9_pkg::fl_f(kf9_pkg::fo_f(l, kv, rnd_q), kv, rnd_q);
    end
    nl = r ^ t;
    nr = l;
  end

  assign rnd_out = {nl, nr};

  // padding block from the item being taken or the held one
  always_comb begin
    pad_blk = in_accept_i ? data_block_i : blk_q;
    pad_vb  = in_accept_i ? valid_bits_i : vb_q;
    v       = pad_vb[6] ? 6'd0 : pad_vb[5:0];
    mask    = (v == 6'd0) ? 64'd0 : ~(64'hFFFFFFFFFFFFFFFF >> v);
    msg     = pad_blk & mask;
    cat     = {count_value_i, fresh_value_i};
    if (v == 6'd63) pad = msg | {63'd0, direction_i};
    else pad = msg | ({63'd0, direction_i} << (6'd63 - v))
                   | (64'd1 << (6'd62 - v));
  end

  assign pin = ctrl_i.chain_done ? rnd_out : chain_q;

  always_comb begin
    state_d = state_q;
    chain_d = chain_q;
    acc_d   = acc_q;
    blk_d   = blk_q;
    vb_d    = vb_q;
    fin_d   = fin_q;
    rnd_d   = rnd_q;
    if (in_accept_i) begin
      blk_d = data_block_i;
      vb_d  = valid_bits_i;
    end
    if (ctrl_i.run) begin
      state_d = rnd_out;
      rnd_d   = rnd_q + 3'd1;
    end
    if (ctrl_i.chain_done) begin
      chain_d = rnd_out;
      acc_d   = acc_q ^ rnd_out;
      state_d = rnd_out ^ blk_q;
    end
    if (ctrl_i.load_init) begin
      state_d = cat;
    end else if (ctrl_i.load_pad) begin
      state_d = pin ^ pad;
    end else if (in_accept_i) begin
      state_d = chain_q ^ data_block_i;
    end
    if (ctrl_i.load_extra) state_d = rnd_out ^ OneBitBlk;
    if (ctrl_i.load_final) begin
      state_d = acc_d;
      fin_d   = 1'b1;
    end
    if (ctrl_i.clear) begin
      chain_d = '0;
      acc_d   = '0;
      fin_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      chain_q <= '0;
      acc_q   <= '0;
      blk_q   <= '0;
      vb_q    <= '0;
      fin_q   <= 1'b0;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      chain_q <= chain_d;
      acc_q   <= acc_d;
      blk_q   <= blk_d;
      vb_q    <= vb_d;
      fin_q   <= fin_d;
      rnd_q   <= rnd_d;
    end
  end

  assign mac_value_o = state_q[63:32];
endmodule

[hdl/kasumi_f9_integrity_mac.sv]
// top level of the kasumi f9 integrity mac
`timescale 1ns / 1ps
// Computes the 32-bit f9 MAC-I over a message fed as 64-bit blocks, first bit
// in bit 63. One shared round unit does one KASUMI round per cycle, and
// in_ready_o is high only while the block is idle, so a new block is taken
// only once the ciphers for the last one are done. The first block of a
// message is preceded by a cipher over count/fresh. A last block with fewer
// than 64 bits is chained as the padding block itself; a full last block is
// chained and then followed by a padding block, and 63 bits add an extra
// block. After the final cipher, mac_value_o is held until taken; no item is
// accepted meanwhile. Registers must be written only while the block is idle;
// the block itself does not enforce this. Count and fresh are read at the
// first block of a message.
module kasumi_f9_integrity_mac (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] data_block_i,
  input  logic [6:0]  valid_bits_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] mac_value_o
);
  localparam logic [2:0] REG_IKU = 3'd0;
  localparam logic [2:0] REG_IKL = 3'd1;
  localparam logic [2:0] REG_CNT = 3'd2;
  localparam logic [2:0] REG_FRS = 3'd3;
  localparam logic [2:0] REG_DIR = 3'd4;

  logic [63:0] iku_q, ikl_q;
  logic [31:0] cnt_q, frs_q;
  logic        dir_q;
  kf9_pkg::ctrl_t ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iku_q <= '0;
      ikl_q <= '0;
      cnt_q <= '0;
      frs_q <= '0;
      dir_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_IKU: iku_q <= cfg_data_i;
        REG_IKL: ikl_q <= cfg_data_i;
        REG_CNT: cnt_q <= cfg_data_i[31:0];
        REG_FRS: frs_q <= cfg_data_i[31:0];
        REG_DIR: dir_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  kf9_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .last_i, .valid_bits_i, .out_ready_i,
    .in_ready_o, .out_valid_o, .ctrl_o(ctrl)
  );

  kf9_dpath u_dpath (
    .clk_i, .rst_ni, .ctrl_i(ctrl),
    .ik_upper_i(iku_q), .ik_lower_i(ikl_q),
    .count_value_i(cnt_q), .fresh_value_i(frs_q), .direction_i(dir_q),
    .in_accept_i(in_valid_i && in_ready_o),
    .data_block_i, .valid_bits_i, .mac_value_o
  );
endmodule
